// File: sv/va_pkg.sv
// Package: widths, opcodes, item types and shared arithmetic for the vector unit.
package va_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 4;
  localparam int MULS       = 6;

  localparam int PROD_W = 2 * DATA_WIDTH - FRAC_BITS;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = TERM_W + 3;

  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = (DATA_WIDTH + FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NUM_W        = DIV_STAGES * DIV_STEPS;
  localparam int ARITH_STAGES = 5;
  localparam int PIPE_STAGES  = DIV_STAGES + 2;
  localparam int DELAY_STAGES = PIPE_STAGES - 1 - ARITH_STAGES;

  localparam int IN_DATA_W  = ((9 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((LANES * DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_SCALE = 3'd3,
    OP_DOT   = 3'd4,
    OP_DIV   = 3'd5,
    OP_CROSS = 3'd6
  } op_t;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [DATA_WIDTH-1:0] mag_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam mag_t POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam mag_t NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam sum_t SUM_MAX = sum_t'(POS_LIM);
  localparam sum_t SUM_MIN = -SUM_MAX - sum_t'(1);

  typedef struct packed {
    op_t                  op;
    word_t [LANES-1:0]    a;
    word_t [LANES-1:0]    b;
    word_t                k;
  } item_t;

  typedef struct packed {
    word_t [LANES-1:0] r;
    logic              sat;
    logic              dbz;
    op_t               op;
    logic              kzero;
  } result_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    mag_t             rem;
    mag_t             q;
    logic             ovf;
    mag_t             d;
    logic             neg;
  } div_t;

  typedef div_t [LANES-1:0] div_lanes_t;

  typedef struct packed {
    word_t v;
    logic  over;
  } clamp_t;

  function automatic mag_t magnitude(word_t x);
    return x[DATA_WIDTH-1] ? (mag_t'(0) - mag_t'(x)) : mag_t'(x);
  endfunction

  function automatic clamp_t clamp(sum_t s);
    clamp_t c;
    c.over = 1'b0;
    c.v    = word_t'(s[DATA_WIDTH-1:0]);
    if (s > SUM_MAX) begin
      c.v    = word_t'(POS_LIM);
      c.over = 1'b1;
    end else if (s < SUM_MIN) begin
      c.v    = word_t'(NEG_LIM);
      c.over = 1'b1;
    end
    return c;
  endfunction

  function automatic div_t div_step(div_t s);
    logic [DATA_WIDTH:0] r2;
    div_t o;
    o     = s;
    r2    = {s.rem, s.num[NUM_W-1]};
    o.num = s.num << 1;
    o.ovf = s.ovf | s.q[DATA_WIDTH-1];
    o.q   = s.q << 1;
    if (r2 >= {1'b0, s.d}) begin
      r2     = r2 - {1'b0, s.d};
      o.q[0] = 1'b1;
    end
    o.rem = r2[DATA_WIDTH-1:0];
    return o;
  endfunction

  function automatic clamp_t div_finish(div_t s);
    clamp_t c;
    c.over = s.ovf || (s.q > (s.neg ? NEG_LIM : POS_LIM));
    if (c.over) begin
      c.v = s.neg ? word_t'(NEG_LIM) : word_t'(POS_LIM);
    end else begin
      c.v = s.neg ? word_t'(mag_t'(0) - s.q) : word_t'(s.q);
    end
    return c;
  endfunction

endpackage

// File: sv/va_div_stage.sv
// One pipelined group of restoring division steps for all four lanes.
module va_div_stage
  import va_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  div_lanes_t d_in,
  output div_lanes_t d_out
);

  div_lanes_t nxt;

  always_comb begin
    nxt = d_in;
    for (int i = 0; i < LANES; i++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        nxt[i] = div_step(nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// File: sv/va_arith.sv
// Multiply and add path: operand select, products, signs, lane sums, clamp.
module va_arith
  import va_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  item_t      item,
  output result_t    res,
  output div_lanes_t seed
);

  localparam int CA [MULS] = '{1, 2, 2, 0, 0, 1};
  localparam int CB [MULS] = '{2, 1, 0, 2, 1, 0};

  // stage 1
  op_t                 op1;
  logic                kz1;
  word_t [LANES-1:0]   a1;
  word_t [LANES-1:0]   b1;
  mag_t  [MULS-1:0]    mx1;
  mag_t  [MULS-1:0]    my1;
  logic  [MULS-1:0]    ps1;
  // stage 2
  op_t                 op2;
  logic                kz2;
  word_t [LANES-1:0]   a2;
  word_t [LANES-1:0]   b2;
  logic  [PROD_W-1:0]  pm2 [MULS];
  logic  [MULS-1:0]    ps2;
  // stage 3
  op_t                 op3;
  logic                kz3;
  word_t [LANES-1:0]   a3;
  logic signed [TERM_W-1:0]     t3 [MULS];
  logic signed [DATA_WIDTH:0]   s3 [LANES];
  // stage 4
  op_t                 op4;
  logic                kz4;
  sum_t                v4 [LANES];

  mag_t  [LANES-1:0]   am;
  mag_t  [LANES-1:0]   bm;
  mag_t                km;
  mag_t  [MULS-1:0]    mx;
  mag_t  [MULS-1:0]    my;
  logic  [MULS-1:0]    ps;
  div_lanes_t          seed_next;

  always_comb begin
    km = magnitude(item.k);
    for (int i = 0; i < LANES; i++) begin
      am[i] = magnitude(item.a[i]);
      bm[i] = magnitude(item.b[i]);
      seed_next[i].num = NUM_W'(am[i]) << FRAC_BITS;
      seed_next[i].rem = '0;
      seed_next[i].q   = '0;
      seed_next[i].ovf = 1'b0;
      seed_next[i].d   = km;
      seed_next[i].neg = item.a[i][DATA_WIDTH-1] ^ item.k[DATA_WIDTH-1];
    end
    for (int j = 0; j < MULS; j++) begin
      mx[j] = '0;
      my[j] = '0;
      ps[j] = 1'b0;
    end
    if (item.op == OP_CROSS) begin
      for (int j = 0; j < MULS; j++) begin
        mx[j] = am[CA[j]];
        my[j] = bm[CB[j]];
        ps[j] = item.a[CA[j]][DATA_WIDTH-1] ^ item.b[CB[j]][DATA_WIDTH-1];
      end
    end else if (item.op == OP_DOT) begin
      for (int i = 0; i < LANES; i++) begin
        mx[i] = am[i];
        my[i] = bm[i];
        ps[i] = item.a[i][DATA_WIDTH-1] ^ item.b[i][DATA_WIDTH-1];
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        mx[i] = am[i];
        my[i] = km;
        ps[i] = item.a[i][DATA_WIDTH-1] ^ item.k[DATA_WIDTH-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= item.op;
      kz1  <= (item.k == '0);
      a1   <= item.a;
      b1   <= item.b;
      mx1  <= mx;
      my1  <= my;
      ps1  <= ps;
      seed <= seed_next;
    end
  end

  logic [2*DATA_WIDTH-1:0] full [MULS];

  always_comb begin
    for (int j = 0; j < MULS; j++) begin
      full[j] = {{DATA_WIDTH{1'b0}}, mx1[j]} * {{DATA_WIDTH{1'b0}}, my1[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      kz2 <= kz1;
      a2  <= a1;
      b2  <= b1;
      ps2 <= ps1;
      for (int j = 0; j < MULS; j++) begin
        pm2[j] <= full[j][2*DATA_WIDTH-1:FRAC_BITS];
      end
    end
  end

  logic signed [TERM_W-1:0]   t_next [MULS];
  logic signed [DATA_WIDTH:0] s_next [LANES];

  always_comb begin
    for (int j = 0; j < MULS; j++) begin
      t_next[j] = ps2[j] ? -$signed({1'b0, pm2[j]}) : $signed({1'b0, pm2[j]});
    end
    for (int i = 0; i < LANES; i++) begin
      unique case (op2)
        OP_ADD:  s_next[i] = (DATA_WIDTH+1)'(a2[i]) + (DATA_WIDTH+1)'(b2[i]);
        OP_SUB:  s_next[i] = (DATA_WIDTH+1)'(a2[i]) - (DATA_WIDTH+1)'(b2[i]);
        OP_NEG:  s_next[i] = -(DATA_WIDTH+1)'(a2[i]);
        default: s_next[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3 <= op2;
      kz3 <= kz2;
      a3  <= a2;
      t3  <= t_next;
      s3  <= s_next;
    end
  end

  sum_t v_next [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      v_next[i] = '0;
    end
    unique case (op3)
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < LANES; i++) begin
          v_next[i] = SUM_W'(s3[i]);
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          v_next[i] = SUM_W'(t3[i]);
        end
      end
      OP_DOT: begin
        v_next[0] = SUM_W'(t3[0]) + SUM_W'(t3[1]);
        v_next[1] = SUM_W'(t3[2]) + SUM_W'(t3[3]);
      end
      OP_CROSS: begin
        v_next[0] = SUM_W'(t3[0]) - SUM_W'(t3[1]);
        v_next[1] = SUM_W'(t3[2]) - SUM_W'(t3[3]);
        v_next[2] = SUM_W'(t3[4]) - SUM_W'(t3[5]);
      end
      OP_DIV: begin
        if (kz3) begin
          for (int i = 0; i < LANES; i++) begin
            if (a3[i] != '0) begin
              v_next[i] = a3[i][DATA_WIDTH-1] ? (SUM_MIN - sum_t'(1)) : (SUM_MAX + sum_t'(1));
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op4 <= op3;
      kz4 <= kz3;
      v4  <= v_next;
    end
  end

  result_t res_next;
  clamp_t  c [LANES];
  sum_t    lane [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane[i] = v4[i];
    end
    if (op4 == OP_DOT) begin
      lane[0] = v4[0] + v4[1];
      for (int i = 1; i < LANES; i++) begin
        lane[i] = '0;
      end
    end
    res_next.sat = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      c[i] = clamp(lane[i]);
      res_next.r[i] = c[i].v;
      res_next.sat  = res_next.sat | c[i].over;
    end
    res_next.dbz   = (op4 == OP_DIV) && kz4;
    res_next.op    = op4;
    res_next.kzero = kz4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// File: sv/vec4_arithmetic_unit.sv
// Top level: four-lane Q16.16 vector ALU with add, sub, negate, scale, dot, divide, cross.
// Fully pipelined, one item per cycle while the output is not stalled; 26 register stages
// lie between acceptance and a valid result, a depth set by the divider, which resolves two
// quotient bits per stage over 48 bits; all other operations travel through a matching delay
// line. The whole pipeline advances together: it holds when a result waits on the output and
// m_axis_tready is low. Products and quotients truncate toward zero, overflow saturates and
// sets the flag, division by zero gives full scale with the sign of each nonzero component.
module vec4_arithmetic_unit
  import va_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_k
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // r_x, r_y, r_z, r_w
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated, divide_by_zero
  output logic [1:0]            m_axis_tuser
);

  logic                   en;
  logic [PIPE_STAGES-1:0] vld;
  item_t                  item;
  result_t                ares;
  result_t                dly [DELAY_STAGES];
  div_lanes_t             dchain [DIV_STAGES+1];
  word_t [LANES-1:0]      r_out;
  logic                   sat_out;
  logic                   dbz_out;
  result_t                fin;
  clamp_t                 qc [LANES];

  assign en            = !vld[PIPE_STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_STAGES-1];
  assign m_axis_tdata  = OUT_DATA_W'(r_out);
  assign m_axis_tuser  = {dbz_out, sat_out};

  always_comb begin
    item.op = op_t'(s_axis_tuser);
    for (int i = 0; i < LANES; i++) begin
      item.a[i] = word_t'(s_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH]);
      item.b[i] = word_t'(s_axis_tdata[(LANES+i)*DATA_WIDTH +: DATA_WIDTH]);
    end
    item.k = word_t'(s_axis_tdata[2*LANES*DATA_WIDTH +: DATA_WIDTH]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_STAGES-2:0], s_axis_tvalid};
    end
  end

  va_arith u_arith (
    .clk  (clk),
    .en   (en),
    .item (item),
    .res  (ares),
    .seed (dchain[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    va_div_stage u_stage (
      .clk   (clk),
      .en    (en),
      .d_in  (dchain[g]),
      .d_out (dchain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= ares;
      for (int i = 1; i < DELAY_STAGES; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  always_comb begin
    fin = dly[DELAY_STAGES-1];
    for (int i = 0; i < LANES; i++) begin
      qc[i] = div_finish(dchain[DIV_STAGES][i]);
    end
    if (fin.op == OP_DIV && !fin.kzero) begin
      fin.sat = 1'b0;
      for (int i = 0; i < LANES; i++) begin
        fin.r[i] = qc[i].v;
        fin.sat  = fin.sat | qc[i].over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out   <= fin.r;
      sat_out <= fin.sat;
      dbz_out <= fin.dbz;
    end
  end

endmodule

// File: sv/va_checker.sv
// Port checker for the vector unit and its bind to the top level.
module va_checker
  import va_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [2:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held without output stall");

  a_dbz_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] && (m_axis_tdata != '0) |-> m_axis_tuser[0])
    else $error("divide by zero with nonzero result not saturated");

endmodule

bind vec4_arithmetic_unit va_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
